/* hw/rtl/tesp_pkg.sv */
// Shared types, constants and handshake structs of the timed event sequence player.
`timescale 1ns / 1ps

package tesp_pkg;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_POLL   = 2'd2;

  localparam logic [7:0] DELAY_MARK = 8'd255;

  typedef struct packed {
    logic [1:0]         operation;
    logic [31:0]        event_time;
    logic signed [15:0] event_value;
    logic [7:0]         event_type;
    logic [7:0]         event_id;
    logic [31:0]        elapsed_us;
  } in_t;

  typedef struct packed {
    logic               is_event;
    logic [7:0]         out_type;
    logic [7:0]         out_id;
    logic signed [15:0] out_value;
    logic [31:0]        out_hold_us;
    logic               finished;
    logic               table_empty;
    logic               overflow;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [31:0] hold_us;
    logic [15:0] value;
    logic [7:0]  ev_type;
    logic [7:0]  ev_id;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic take;         // accept the input beat
    logic walk_step;    // consume the current table entry
    logic set_waiting;  // walk stopped on a future deadline
    logic emit_status;  // load the closing status beat
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_poll;
    logic more;
    logic cur_delay;
    logic cur_wait;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/tesp_ctrl.sv */
// Controller state machine of the timed event sequence player.
`timescale 1ns / 1ps

module tesp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tesp_pkg::sts_t  sts_i,
  output tesp_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_STAT = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = sts_i.is_poll ? ST_PREP : ST_STAT;
        end
      end
      // wait in ST_PREP for the registered table read
      ST_PREP: state_d = ST_WALK;
      ST_WALK: begin
        if (!sts_i.more) begin
          state_d = ST_STAT;
        end else if (sts_i.cur_delay) begin
          cmd_o.walk_step = 1'b1;
        end else if (sts_i.cur_wait) begin
          cmd_o.set_waiting = 1'b1;
          state_d           = ST_STAT;
        end else if (sts_i.out_free) begin
          cmd_o.walk_step = 1'b1;
        end
      end
      ST_STAT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/tesp_dp.sv */
// Datapath of the timed event sequence player: event table, step and deadline, output beat.
`timescale 1ns / 1ps

module tesp_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tesp_pkg::in_t   in_beat_i,
  input  tesp_pkg::cmd_t  cmd_i,
  output tesp_pkg::sts_t  sts_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tesp_pkg::out_t  out_beat_o
);

  localparam int unsigned DEPTH_ROWS = tesp_pkg::DEPTH;
  tesp_pkg::entry_t mem [DEPTH_ROWS];

  tesp_pkg::entry_t rd_q;

  logic [tesp_pkg::CNT_W-1:0] count_q, count_d;
  logic [tesp_pkg::CNT_W-1:0] step_q, step_d;
  logic [31:0]                deadline_q, deadline_d;
  logic [31:0]                elapsed_q;
  logic                       poll_q, ovf_q, waiting_q;
  logic                       out_valid_q;
  tesp_pkg::out_t             out_q;

  logic full, do_write, fin, out_free, emit_ev;

  assign full     = (count_q == tesp_pkg::CNT_W'(tesp_pkg::DEPTH));
  assign do_write = cmd_i.take && (in_beat_i.operation == tesp_pkg::OP_APPEND) && !full;
  assign fin      = poll_q && !waiting_q && !(elapsed_q < deadline_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign emit_ev  = cmd_i.walk_step &&
                    !((rd_q.ev_type == tesp_pkg::DELAY_MARK) &&
                      (rd_q.ev_id == tesp_pkg::DELAY_MARK));

  assign sts_o.is_poll   = (in_beat_i.operation == tesp_pkg::OP_POLL);
  assign sts_o.more      = (step_q < count_q);
  assign sts_o.cur_delay = (rd_q.ev_type == tesp_pkg::DELAY_MARK) &&
                           (rd_q.ev_id == tesp_pkg::DELAY_MARK);
  assign sts_o.cur_wait  = (elapsed_q < deadline_q);
  assign sts_o.out_free  = out_free;

  always_comb begin
    count_d = count_q;
    if (do_write) begin
      count_d = count_q + tesp_pkg::CNT_W'(1);
    end else if (cmd_i.take && (in_beat_i.operation == tesp_pkg::OP_CLEAR)) begin
      count_d = '0;
    end
  end

  always_comb begin
    step_d     = step_q;
    deadline_d = deadline_q;
    if (cmd_i.walk_step) begin
      step_d     = step_q + tesp_pkg::CNT_W'(1);
      deadline_d = deadline_q + rd_q.hold_us;
    end else if (cmd_i.emit_status && fin) begin
      // sequence done: rewind
      step_d     = '0;
      deadline_d = '0;
    end
  end

  // table: one write port, one registered read port that follows the step
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[count_q[tesp_pkg::IDX_W-1:0]] <= '{hold_us: in_beat_i.event_time,
                                             value:   in_beat_i.event_value,
                                             ev_type: in_beat_i.event_type,
                                             ev_id:   in_beat_i.event_id};
    end
    rd_q <= mem[step_d[tesp_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      step_q     <= '0;
      deadline_q <= '0;
      poll_q     <= 1'b0;
      ovf_q      <= 1'b0;
      waiting_q  <= 1'b0;
    end else begin
      count_q    <= count_d;
      step_q     <= step_d;
      deadline_q <= deadline_d;
      if (cmd_i.take) begin
        poll_q    <= (in_beat_i.operation == tesp_pkg::OP_POLL);
        ovf_q     <= (in_beat_i.operation == tesp_pkg::OP_APPEND) && full;
        waiting_q <= 1'b0;
      end else if (cmd_i.set_waiting) begin
        waiting_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      elapsed_q <= in_beat_i.elapsed_us;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ev || cmd_i.emit_status) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ev) begin
      out_q.is_event    <= 1'b1;
      out_q.out_type    <= rd_q.ev_type;
      out_q.out_id      <= rd_q.ev_id;
      out_q.out_value   <= rd_q.value;
      out_q.out_hold_us <= rd_q.hold_us;
      out_q.finished    <= 1'b0;
      out_q.table_empty <= (count_q == '0);
      out_q.overflow    <= 1'b0;
      out_q.last        <= 1'b0;
    end else if (cmd_i.emit_status) begin
      out_q.is_event    <= 1'b0;
      out_q.out_type    <= '0;
      out_q.out_id      <= '0;
      out_q.out_value   <= '0;
      out_q.out_hold_us <= '0;
      out_q.finished    <= fin;
      out_q.table_empty <= (count_q == '0);
      out_q.overflow    <= ovf_q;
      out_q.last        <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tesp_pkg::CNT_W'(tesp_pkg::DEPTH))
    else $error("event count beyond table depth");

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_ev || cmd_i.emit_status) |-> out_free)
    else $error("result loaded over an untaken beat");

  a_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_status && fin) |=> (step_q == '0 && deadline_q == '0))
    else $error("finished poll did not rewind step and deadline");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_step |-> (step_q < count_q))
    else $error("walk stepped past the last event");

endmodule

/* hw/rtl/timed_event_sequence_player_top.sv */
// Top level of the timed event sequence player.
//
//   beat    direction  payload             meaning
//   in      sink       tesp_pkg::in_t      append, clear or poll request
//   out     source     tesp_pkg::out_t     event beats, then one status beat
//
// One request is handled at a time. Append, clear and an unused code go from
// the accept straight to the status beat. A poll goes through the accept, the
// registered table read, the walk over the table entries, the check that finds
// the end or a future deadline, and the status beat; the walk is paced by the
// single read port of the event table.
// Reset clears count, step and deadline at once; the table needs no clearing.
// A stalled output holds the walk until the beat is taken.
`timescale 1ns / 1ps

module timed_event_sequence_player_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tesp_pkg::in_t   in_beat_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tesp_pkg::out_t  out_beat_o
);

  tesp_pkg::cmd_t cmd;
  tesp_pkg::sts_t sts;

  tesp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tesp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

/* tb/tesp_beat_checker.sv */
// Beat checker for the timed event sequence player: predicts each output beat and compares it.
`timescale 1ns / 1ps

module tesp_beat_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  tesp_pkg::in_t  in_beat_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  tesp_pkg::out_t out_beat_i,
  output int             mismatches_o,
  output int             pending_o,
  output int             beats_o,
  output int             events_o,
  output int             finishes_o,
  output int             overflows_o
);

  import tesp_pkg::*;

  entry_t           seq_table [DEPTH];
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] play_step;
  logic [31:0]      deadline;
  out_t             due_beats [$];
  out_t             want;

  function automatic string beat_text(input out_t b);
    return $sformatf({"ev=%0b type=%0d id=%0d value=%0d hold=%0d",
                      " fin=%0b empty=%0b ovf=%0b last=%0b"},
                     b.is_event, b.out_type, b.out_id, b.out_value, b.out_hold_us,
                     b.finished, b.table_empty, b.overflow, b.last);
  endfunction

  // Update the table, step and deadline for one request and queue the beats it causes.
  task automatic play_request(input in_t req);
    out_t   beat;
    entry_t ent;
    logic   waiting;
    logic   done;
    logic   dropped;
    waiting = 1'b0;
    done    = 1'b0;
    dropped = 1'b0;
    case (req.operation)
      OP_APPEND: begin
        if (entry_count >= DEPTH) begin
          dropped = 1'b1;
        end else begin
          ent.hold_us = req.event_time;
          ent.value   = req.event_value;
          ent.ev_type = req.event_type;
          ent.ev_id   = req.event_id;
          seq_table[entry_count] = ent;
          entry_count = entry_count + 1'b1;
        end
      end
      OP_CLEAR: begin
        entry_count = '0;
      end
      OP_POLL: begin
        while (!waiting && play_step < entry_count) begin
          ent = seq_table[play_step];
          if (ent.ev_type == DELAY_MARK && ent.ev_id == DELAY_MARK) begin
            deadline  = deadline + ent.hold_us;
            play_step = play_step + 1'b1;
          end else if (req.elapsed_us < deadline) begin
            waiting = 1'b1;
          end else begin
            beat             = '0;
            beat.is_event    = 1'b1;
            beat.out_type    = ent.ev_type;
            beat.out_id      = ent.ev_id;
            beat.out_value   = ent.value;
            beat.out_hold_us = ent.hold_us;
            beat.table_empty = (entry_count == 0);
            due_beats.insert(due_beats.size(), beat);
            deadline  = deadline + ent.hold_us;
            play_step = play_step + 1'b1;
          end
        end
        if (!waiting && req.elapsed_us >= deadline) begin
          done      = 1'b1;
          play_step = '0;
          deadline  = '0;
        end
      end
      default: begin
      end
    endcase
    beat             = '0;
    beat.finished    = done;
    beat.overflow    = dropped;
    beat.table_empty = (entry_count == 0);
    beat.last        = 1'b1;
    due_beats.insert(due_beats.size(), beat);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count  = '0;
      play_step    = '0;
      deadline     = '0;
      due_beats.delete();
      mismatches_o = 0;
      pending_o    = 0;
      beats_o      = 0;
      events_o     = 0;
      finishes_o   = 0;
      overflows_o  = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        play_request(in_beat_i);
      end
      if (out_valid_i && out_ready_i) begin
        beats_o++;
        if (due_beats.size() == 0) begin
          if (mismatches_o < 10) begin
            $display("%0t: output beat with nothing due: %s", $time, beat_text(out_beat_i));
          end
          mismatches_o++;
        end else begin
          want = due_beats.pop_front();
          events_o    += want.is_event;
          finishes_o  += want.finished;
          overflows_o += want.overflow;
          if (out_beat_i.is_event    !== want.is_event    ||
              out_beat_i.out_type    !== want.out_type    ||
              out_beat_i.out_id      !== want.out_id      ||
              out_beat_i.out_value   !== want.out_value   ||
              out_beat_i.out_hold_us !== want.out_hold_us ||
              out_beat_i.finished    !== want.finished    ||
              out_beat_i.table_empty !== want.table_empty ||
              out_beat_i.overflow    !== want.overflow    ||
              out_beat_i.last        !== want.last) begin
            if (mismatches_o < 10) begin
              $display("%0t: output beat mismatch", $time);
              $display("  expected %s", beat_text(want));
              $display("  actual   %s", beat_text(out_beat_i));
            end
            mismatches_o++;
          end
        end
      end
      pending_o = due_beats.size();
    end
  end

endmodule

/* tb/timed_event_sequence_player_top_tb.sv */
// Stimulus, reset, clock and verdict for the timed event sequence player.
`timescale 1ns / 1ps

module timed_event_sequence_player_top_tb;

  import tesp_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         HOLD_OFF_LEN   = 200;
  localparam int         RANDOM_ITEMS   = 240;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  in_t            in_beat_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  out_t           out_beat_o;

  int             mismatches;
  int             pending;
  int             beats_seen;
  int             events_seen;
  int             finishes_seen;
  int             overflows_seen;
  int             items_sent        = 0;
  int             hold_off_requests = 0;
  int             hold_offs_done    = 0;
  logic           in_idle_on        = 1'b1;
  logic           out_idle_on       = 1'b1;

  always #5 clk_i = ~clk_i;

  timed_event_sequence_player_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  tesp_beat_checker beat_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_beat_i    (in_beat_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_beat_i   (out_beat_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .beats_o      (beats_seen),
    .events_o     (events_seen),
    .finishes_o   (finishes_seen),
    .overflows_o  (overflows_seen)
  );

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_offs_done != hold_off_requests) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_LEN) @(negedge clk_i);
        hold_offs_done++;
      end
      out_ready_i <= !out_idle_on || ($urandom_range(99) >= 34);
    end
  end

  // Called at a falling edge; drops valid at the falling edge after the beat is taken.
  task automatic send_request(input logic [1:0] op, input logic [31:0] ev_time,
                              input logic [15:0] ev_value, input logic [7:0] ev_type,
                              input logic [7:0] ev_id, input logic [31:0] elapsed);
    in_t req;
    @(negedge clk_i);
    while (in_idle_on && $urandom_range(99) < 34) begin
      @(negedge clk_i);
    end
    req.operation   = op;
    req.event_time  = ev_time;
    req.event_value = ev_value;
    req.event_type  = ev_type;
    req.event_id    = ev_id;
    req.elapsed_us  = elapsed;
    in_valid_i <= 1'b1;
    in_beat_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic append_event(input logic [31:0] ev_time, input logic [15:0] ev_value,
                              input logic [7:0] ev_type, input logic [7:0] ev_id);
    send_request(OP_APPEND, ev_time, ev_value, ev_type, ev_id, $urandom);
  endtask

  task automatic poll_at(input logic [31:0] elapsed);
    send_request(OP_POLL, $urandom, 16'($urandom), 8'($urandom), 8'($urandom), elapsed);
  endtask

  task automatic clear_table();
    send_request(OP_CLEAR, $urandom, 16'($urandom), 8'($urandom), 8'($urandom), $urandom);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
  endtask

  // One mostly well-formed run: clear, load events, then poll with rising elapsed time.
  task automatic play_sequence(input int n_events, input int n_polls);
    int          k;
    int unsigned kind;
    logic [31:0] elapsed;
    logic [31:0] ev_time;
    logic [7:0]  ev_type;
    logic [7:0]  ev_id;
    if ($urandom_range(9) < 8) clear_table();
    for (k = 0; k < n_events; k++) begin
      kind    = $urandom_range(99);
      ev_time = ($urandom_range(19) == 0) ? $urandom : $urandom_range(150);
      ev_type = 8'($urandom);
      ev_id   = 8'($urandom);
      if (kind < 25) begin
        ev_type = DELAY_MARK;
        ev_id   = DELAY_MARK;
      end else if (kind < 32) begin
        ev_type = DELAY_MARK;
      end else if (kind < 39) begin
        ev_id = DELAY_MARK;
      end
      append_event(ev_time, 16'($urandom), ev_type, ev_id);
    end
    elapsed = '0;
    for (k = 0; k < n_polls; k++) begin
      elapsed = elapsed + $urandom_range(300);
      poll_at(elapsed);
    end
    if ($urandom_range(9) < 7) poll_at('1);
  endtask

  initial begin
    int k;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: field extremes, wrap of the deadline, clear keeping the step.
    poll_at('0);
    send_request(OP_UNUSED, '1, 16'h8000, '1, '1, '1);
    append_event('0, 16'h8000, 8'd0, 8'd0);
    append_event(32'd100, 16'h7fff, DELAY_MARK, DELAY_MARK);
    append_event('1, 16'h7fff, DELAY_MARK, 8'd0);
    append_event(32'd50, 16'hffff, 8'd0, DELAY_MARK);
    poll_at('0);
    poll_at(32'd100);
    poll_at('1);
    poll_at('0);
    clear_table();
    append_event(32'd5, 16'h1234, 8'h5a, 8'ha5);
    poll_at(32'd50);
    poll_at(32'd100);
    clear_table();
    append_event(32'hffff_fff0, 16'h0001, DELAY_MARK, DELAY_MARK);
    append_event(32'h0000_0020, 16'h8001, 8'h01, 8'hfe);
    poll_at(32'hffff_ffef);
    poll_at('1);
    poll_at(32'h0000_0010);
    send_request(OP_UNUSED, '0, '0, '0, '0, '0);
    clear_table();
    clear_table();

    // Fill past the end while the receiver holds off, then drain before going on.
    wait_drained();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    hold_off_requests++;
    for (k = 0; k < DEPTH + 2; k++) begin
      append_event($urandom_range(20), 16'($urandom), 8'($urandom_range(254)),
                   8'($urandom));
    end
    poll_at('1);
    poll_at('0);
    wait_drained();

    // Random part, with an early stretch where neither side idles.
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    k = 0;
    while (k < RANDOM_ITEMS) begin
      in_idle_on  = !(k >= 60 && k < 130);
      out_idle_on = in_idle_on;
      if ($urandom_range(99) < 15) begin
        send_request(2'($urandom_range(3)), $urandom, 16'($urandom), 8'($urandom),
                     8'($urandom), $urandom);
        k++;
      end else begin
        k -= items_sent;
        if ($urandom_range(99) < 5) begin
          play_sequence($urandom_range(DEPTH - 2, DEPTH + 2), $urandom_range(1, 3));
        end else begin
          play_sequence($urandom_range(1, 8), $urandom_range(1, 5));
        end
        k += items_sent;
      end
    end

    wait_drained();
    repeat (DEPTH + 8) @(negedge clk_i);
    $display("Covered %0d requests and %0d output beats, %0d of them event beats.",
             items_sent, beats_seen, events_seen);
    $display("Sequences run to the end: %0d; appends dropped on a full table: %0d.",
             finishes_seen, overflows_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS timed_event_sequence_player_top");
    end else begin
      $display("FAIL timed_event_sequence_player_top");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d beats still due.", pending);
    $display("FAIL timed_event_sequence_player_top");
    $finish;
  end

endmodule
